[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/uvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Types, constants and the quarter-wave sine table of the UV sphere generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int LEVEL_MAX         = 256;
	localparam int LEVEL_MIN         = 3;
	localparam int LEVEL_RESET       = 16;
	localparam int SINE_DEPTH        = 1024;
	localparam int SINE_DEPTH_LOG2   = 10;
	localparam int PHASE_W           = SINE_DEPTH_LOG2 + 2;
	localparam int ROM_AW            = SINE_DEPTH_LOG2 + 1;
	localparam int LEVEL_W           = 9;
	localparam int QUO_W             = 16;
	localparam int TERM_DIV_W        = 40;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [15:0] sine_rom_t [0:SINE_DEPTH];

	typedef struct packed {
		logic [8:0] column_index;
		logic [7:0] row_index;
	} vertex_req_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic        [15:0] tex_u;
		logic        [15:0] tex_v;
	} vertex_t;

	// truncating quotient by shift and subtract; the dividend stays below 2^TERM_DIV_W
	function automatic longint unsigned term_div(longint unsigned a, longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int i = TERM_DIV_W - 1; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			q = q << 1;
			if (r >= b) begin
				r = r - b;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// round(32768*sin(pi/2*k/D)) from a Taylor series in Q30, evaluated at elaboration
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t         rom;
		longint unsigned   x;
		longint unsigned   x2;
		longint unsigned   term;
		longint            sum;
		longint unsigned   v;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x    = (HALF_PI_Q30 * longint'(k)) >> SINE_DEPTH_LOG2;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 12; n++) begin
				term = term_div((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
				if ((n & 1) == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (longint'(sum) + 16384) >> 15;
			if (v > 32768) begin
				v = 32768;
			end
			rom[k] = v[15:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// fold a phase onto the quarter wave
	function automatic logic [ROM_AW-1:0] rom_index(logic [PHASE_W-1:0] p);
		logic [ROM_AW-1:0] r;
		r = {1'b0, p[SINE_DEPTH_LOG2-1:0]};
		if (p[SINE_DEPTH_LOG2]) begin
			return ROM_AW'(SINE_DEPTH) - r;
		end
		return r;
	endfunction

endpackage

[hw/rtl/uvs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, one quotient bit per stage, fixed divisor.
// ----------------------------------------------------------------------------
module uvs_div #(
	parameter int QW = 16,
	parameter int DW = 9
) (
	input  logic             clk,
	input  logic [QW+DW-1:0] numer,
	input  logic [DW-1:0]    divisor,
	output logic [QW-1:0]    quo
);

	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] low_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];

	// quotient fits QW bits, so the top part starts below the divisor
	assign rem_s[0] = numer[QW+DW-1:QW];
	assign low_s[0] = numer[QW-1:0];
	assign quo_s[0] = '0;

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [DW:0] trial;
		logic        fits;

		always_comb begin
			trial = {rem_s[g], low_s[g][QW-1]};
			fits  = (trial >= {1'b0, divisor});
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= fits ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
			low_s[g+1] <= low_s[g] << 1;
			quo_s[g+1] <= {quo_s[g][QW-2:0], fits};
		end
	end

	assign quo = quo_s[QW];

endmodule

[hw/rtl/uv_sphere_vertex_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top
// One sphere vertex (position, normal, texture coordinates) per item.
// Path: input register, the four dividers, sine table reads, magnitude products
// and the output register, which drives result and result_valid.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Latency is set by the four 16-stage dividers, one quotient bit per stage.
// Reset clears valid bits and sets the level count to 16.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uv_sphere_vertex_generator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  uvs_pkg::vertex_req_t vertex_req,
	output logic                result_valid,
	output uvs_pkg::vertex_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [8:0]          cfg_data
);

	localparam int QW = uvs_pkg::QUO_W;
	localparam int LW = uvs_pkg::LEVEL_W;
	localparam int NW = QW + LW;
	localparam int PW = uvs_pkg::PHASE_W;
	localparam int AW = uvs_pkg::ROM_AW;
	localparam int LATENCY = QW + 4;
	localparam logic [15:0] TEX_ONE = 16'd32768;
	localparam logic signed [15:0] Z_MAX = 16'sd16384;
	localparam uvs_pkg::sine_rom_t PHI_ROM   = uvs_pkg::SINE_ROM;
	localparam uvs_pkg::sine_rom_t THETA_ROM = uvs_pkg::SINE_ROM;

	logic [LW-1:0] n_q;
	logic [LW-1:0] nm1_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// clamp the level count once, at the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= LW'(uvs_pkg::LEVEL_RESET);
			nm1_q <= LW'(uvs_pkg::LEVEL_RESET - 1);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_data < LW'(uvs_pkg::LEVEL_MIN)) begin
				n_q   <= LW'(uvs_pkg::LEVEL_MIN);
				nm1_q <= LW'(uvs_pkg::LEVEL_MIN - 1);
			end else if (cfg_data > LW'(uvs_pkg::LEVEL_MAX)) begin
				n_q   <= LW'(uvs_pkg::LEVEL_MAX);
				nm1_q <= LW'(uvs_pkg::LEVEL_MAX - 1);
			end else begin
				n_q   <= cfg_data;
				nm1_q <= cfg_data - 1'b1;
			end
		end
	end

	// ---- stage 1: input register
	logic                 v_s1;
	uvs_pkg::vertex_req_t req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= vertex_req;
		end
	end

	// clamp indices and form the rounded numerators
	logic [8:0]    col_c;
	logic [8:0]    col_m;
	logic [7:0]    row_c;
	logic [NW-1:0] half_n;
	logic [NW-1:0] half_nm1;
	logic [NW-1:0] num_u;
	logic [NW-1:0] num_phi;
	logic [NW-1:0] num_th;
	logic [NW-1:0] num_v;

	always_comb begin
		col_c    = (req_s1.column_index > n_q) ? n_q : req_s1.column_index;
		col_m    = (col_c == n_q) ? '0 : col_c;
		row_c    = ({1'b0, req_s1.row_index} > nm1_q) ? nm1_q[7:0] : req_s1.row_index;
		half_n   = NW'(n_q >> 1);
		half_nm1 = NW'(nm1_q >> 1);
		num_u    = NW'({col_c, 15'd0}) + half_n;
		num_phi  = NW'({col_m, 12'd0}) + half_n;
		num_th   = NW'({row_c, 11'd0}) + half_nm1;
		num_v    = NW'({row_c, 15'd0}) + half_nm1;
	end

	logic [QW-1:0] q_u;
	logic [QW-1:0] q_phi;
	logic [QW-1:0] q_th;
	logic [QW-1:0] q_v;

	uvs_div #(.QW(QW), .DW(LW)) u_div_u (
		.clk(clk), .numer(num_u), .divisor(n_q), .quo(q_u)
	);
	uvs_div #(.QW(QW), .DW(LW)) u_div_phi (
		.clk(clk), .numer(num_phi), .divisor(n_q), .quo(q_phi)
	);
	uvs_div #(.QW(QW), .DW(LW)) u_div_th (
		.clk(clk), .numer(num_th), .divisor(nm1_q), .quo(q_th)
	);
	uvs_div #(.QW(QW), .DW(LW)) u_div_v (
		.clk(clk), .numer(num_v), .divisor(nm1_q), .quo(q_v)
	);

	logic [QW-1:0] div_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_q <= '0;
		end else begin
			div_vld_q <= {div_vld_q[QW-2:0], v_s1};
		end
	end

	// ---- stage 2: sine table reads
	logic [PW-1:0] ph_phi;
	logic [PW-1:0] ph_phi_c;
	logic [PW-1:0] ph_th;
	logic [PW-1:0] ph_th_c;

	always_comb begin
		ph_phi   = q_phi[PW-1:0];
		ph_th    = q_th[PW-1:0];
		ph_phi_c = ph_phi + PW'(uvs_pkg::SINE_DEPTH);
		ph_th_c  = ph_th + PW'(uvs_pkg::SINE_DEPTH);
	end

	logic        v_s2;
	logic [15:0] sp_s2, cp_s2, st_s2, ct_s2;
	logic        sp_neg_s2, cp_neg_s2, st_neg_s2, ct_neg_s2;
	logic [15:0] u_s2, tv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= div_vld_q[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		sp_s2     <= PHI_ROM[uvs_pkg::rom_index(ph_phi)];
		cp_s2     <= PHI_ROM[uvs_pkg::rom_index(ph_phi_c)];
		st_s2     <= THETA_ROM[uvs_pkg::rom_index(ph_th)];
		ct_s2     <= THETA_ROM[uvs_pkg::rom_index(ph_th_c)];
		sp_neg_s2 <= ph_phi[PW-1];
		cp_neg_s2 <= ph_phi_c[PW-1];
		st_neg_s2 <= ph_th[PW-1];
		ct_neg_s2 <= ph_th_c[PW-1];
		u_s2      <= q_u;
		tv_s2     <= 16'd32768 - q_v;
	end

	// ---- stage 3: magnitude products and the rounded half of the z magnitude
	logic        v_s3;
	logic [31:0] px_mag_s3, py_mag_s3;
	logic [15:0] pz_mag_s3;
	logic        px_neg_s3, py_neg_s3, pz_neg_s3;
	logic [15:0] u_s3, tv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_mag_s3 <= st_s2 * cp_s2;
		py_mag_s3 <= st_s2 * sp_s2;
		pz_mag_s3 <= 16'((17'(ct_s2) + 17'd1) >> 1);
		px_neg_s3 <= st_neg_s2 ^ cp_neg_s2;
		py_neg_s3 <= st_neg_s2 ^ sp_neg_s2;
		pz_neg_s3 <= ct_neg_s2;
		u_s3      <= u_s2;
		tv_s3     <= tv_s2;
	end

	// ---- stage 4: round half away from zero, apply sign, output register
	logic [15:0] px_r, py_r;
	logic [15:0] px_f, py_f, pz_f;

	always_comb begin
		px_r = 16'((px_mag_s3 + 32'd32768) >> 16);
		py_r = 16'((py_mag_s3 + 32'd32768) >> 16);
		px_f = px_neg_s3 ? (16'd0 - px_r) : px_r;
		py_f = py_neg_s3 ? (16'd0 - py_r) : py_r;
		pz_f = pz_neg_s3 ? (16'd0 - pz_mag_s3) : pz_mag_s3;
	end

	logic             v_s4;
	uvs_pkg::vertex_t res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		res_s4.pos_x  <= px_f;
		res_s4.pos_y  <= py_f;
		res_s4.pos_z  <= pz_f;
		res_s4.norm_x <= px_f;
		res_s4.norm_y <= py_f;
		res_s4.norm_z <= pz_f;
		res_s4.tex_u  <= u_s3;
		res_s4.tex_v  <= tv_s3;
	end

	assign result_valid = v_s4;
	assign result       = res_s4;

	logic tex_ok;
	logic z_ok;

	assign tex_ok = (result.tex_u <= TEX_ONE) && (result.tex_v <= TEX_ONE);
	assign z_ok   = (result.pos_z <= Z_MAX) && (result.pos_z >= -Z_MAX);

	`ASSERT_NEXT(a_latency, clk, arst_n, start && !busy, ##(LATENCY-1) result_valid)
	`ASSERT_IMPLIES(a_tex_range, clk, arst_n, result_valid, tex_ok)
	`ASSERT_IMPLIES(a_z_range, clk, arst_n, result_valid, z_ok)

endmodule
